// File: rtl/fmas_pkg.sv
// ----------------------------------------------------------------------------
// fmas_pkg
// Shared constants and stage-to-stage types for the magnitude add/sub pipeline.
// ----------------------------------------------------------------------------
package fmas_pkg;

   localparam int SUM_BITS = 33;
   localparam int SIG_BITS = 24;
   localparam int WIN_BITS = 32;
   localparam int EXP_BITS = 8;
   localparam int LZ_BITS  = 6;

   localparam logic [30:0]          INF_WORD = 31'h7F80_0000;
   localparam logic [EXP_BITS-1:0]  EXP_MAX  = 8'hFF;

   // result kind decided early in the pipe
   localparam logic [1:0] KIND_NORMAL = 2'd0;
   localparam logic [1:0] KIND_ZERO   = 2'd1;
   localparam logic [1:0] KIND_INF    = 2'd2;

   // after ordering / alignment
   typedef struct packed {
      logic                 sub;
      logic [1:0]           kind;
      logic [EXP_BITS-1:0]  exp;
      logic [WIN_BITS-1:0]  w1;
      logic [WIN_BITS-1:0]  w2;
   } align_type;

   // after add/subtract
   typedef struct packed {
      logic                 sub;
      logic [1:0]           kind;
      logic [EXP_BITS-1:0]  exp;
      logic [SUM_BITS-1:0]  acc;
   } sum_type;

   // after normalization
   typedef struct packed {
      logic [1:0]           kind;
      logic signed [9:0]    exp;
      logic [SIG_BITS-2:0]  frac;
   } norm_type;

endpackage

// File: rtl/fmas_align.sv
// ----------------------------------------------------------------------------
// fmas_align
// Unpacks both words, orders them by magnitude and aligns the smaller one.
// ----------------------------------------------------------------------------
module fmas_align (
   input  logic               op,
   input  logic [31:0]        operand_a,
   input  logic [31:0]        operand_b,
   output fmas_pkg::align_type aln
);

   logic [7:0]  ea, eb, e1, e2, d;
   logic [23:0] ma, mb, m1, m2;
   logic        swap;

   always_comb begin
      ea   = operand_a[30:23];
      eb   = operand_b[30:23];
      ma   = (ea == 8'd0) ? 24'd0 : {1'b1, operand_a[22:0]};
      mb   = (eb == 8'd0) ? 24'd0 : {1'b1, operand_b[22:0]};
      swap = (eb > ea) || ((eb == ea) && (mb > ma));
      e1   = swap ? eb : ea;
      e2   = swap ? ea : eb;
      m1   = swap ? mb : ma;
      m2   = swap ? ma : mb;
      d    = e1 - e2;

      aln.sub = op;
      aln.exp = e1;
      aln.w1  = {m1, 8'd0};
      aln.w2  = (d >= 8'd32) ? 32'd0 : ({m2, 8'd0} >> d[4:0]);
      if (ea == fmas_pkg::EXP_MAX || eb == fmas_pkg::EXP_MAX)
         aln.kind = fmas_pkg::KIND_INF;
      else if (m1 == 24'd0)
         aln.kind = fmas_pkg::KIND_ZERO;
      else
         aln.kind = fmas_pkg::KIND_NORMAL;
   end

endmodule

// File: rtl/fmas_norm.sv
// ----------------------------------------------------------------------------
// fmas_norm
// Normalizes the sum or difference: carry shift or leading-zero shift.
// ----------------------------------------------------------------------------
module fmas_norm (
   input  fmas_pkg::sum_type  sm,
   output fmas_pkg::norm_type nm
);

   logic [fmas_pkg::LZ_BITS-1:0] lz;
   logic [31:0] sh;
   logic        found;

   always_comb begin
      lz    = 6'd0;
      found = 1'b0;
      for (int i = 31; i >= 0; i--) begin
         if (!found && sm.acc[i]) begin
            found = 1'b1;
            lz    = 6'(31 - i);
         end
      end
      sh      = sm.acc[31:0] << lz[4:0];
      nm.kind = sm.kind;
      nm.exp  = {2'b00, sm.exp};
      nm.frac = sm.acc[30:8];
      if (sm.kind == fmas_pkg::KIND_NORMAL) begin
         if (!sm.sub) begin
            if (sm.acc[32]) begin
               nm.frac = sm.acc[31:9];
               nm.exp  = {2'b00, sm.exp} + 10'sd1;
            end
         end else if (sm.acc[31:0] == 32'd0) begin
            nm.kind = fmas_pkg::KIND_ZERO;
         end else begin
            nm.frac = sh[30:8];
            nm.exp  = {2'b00, sm.exp} - {4'd0, lz};
         end
      end
   end

endmodule

// File: rtl/float_magnitude_add_sub.sv
// ----------------------------------------------------------------------------
// float_magnitude_add_sub
// Four-stage magnitude adder/subtractor for single-precision words.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries op (0 add, 1 larger minus smaller) and two words
//   whose sign bits are ignored. rsp_ channel returns a 31-bit non-negative
//   word, a zero flag and an exponent overflow flag. One result per item,
//   in order.
//   Each item passes the align, add, normalize and pack stages before
//   rsp_valid. Throughput: one item per cycle; the pipe advances
//   whenever its last stage is empty or being taken.
//   When the receiver stalls the whole pipe holds; req_ready drops only
//   while the output stage is full and not taken. Nothing is lost or
//   repeated. Reset (synchronous) empties all stages.
//   Truncating arithmetic, no rounding; subnormals read as zero; an
//   infinity or NaN operand gives infinity without overflow.
// ----------------------------------------------------------------------------
module float_magnitude_add_sub (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [30:0] rsp_result_word,
   output logic        rsp_result_is_zero,
   output logic        rsp_overflow
);

   logic advance;
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   fmas_pkg::align_type aln_in, s1_ff;
   fmas_pkg::sum_type   sum_in, s2_ff;
   fmas_pkg::norm_type  nrm_in, s3_ff;
   logic [30:0] word_in, word_ff;
   logic        ovf_in, ovf_ff;

   assign advance   = !v4_ff || rsp_ready;
   assign req_ready = advance;

   fmas_align u_align (
      .op        (req_op),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .aln       (aln_in)
   );

   always_comb begin
      sum_in.sub  = s1_ff.sub;
      sum_in.kind = s1_ff.kind;
      sum_in.exp  = s1_ff.exp;
      if (s1_ff.sub)
         sum_in.acc = {1'b0, s1_ff.w1 - s1_ff.w2};
      else
         sum_in.acc = {1'b0, s1_ff.w1} + {1'b0, s1_ff.w2};
   end

   fmas_norm u_norm (
      .sm (s2_ff),
      .nm (nrm_in)
   );

   always_comb begin
      word_in = 31'd0;
      ovf_in  = 1'b0;
      case (s3_ff.kind)
         fmas_pkg::KIND_INF:  word_in = fmas_pkg::INF_WORD;
         fmas_pkg::KIND_ZERO: word_in = 31'd0;
         default: begin
            if (s3_ff.exp <= 10'sd0) begin
               word_in = 31'd0;
            end else if (s3_ff.exp >= 10'sd255) begin
               word_in = fmas_pkg::INF_WORD;
               ovf_in  = 1'b1;
            end else begin
               word_in = {s3_ff.exp[7:0], s3_ff.frac};
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      if (advance) begin
         s1_ff   <= aln_in;
         s2_ff   <= sum_in;
         s3_ff   <= nrm_in;
         word_ff <= word_in;
         ovf_ff  <= ovf_in;
      end
   end

   assign rsp_valid          = v4_ff;
   assign rsp_result_word    = word_ff;
   assign rsp_result_is_zero = (word_ff == 31'd0);
   assign rsp_overflow       = ovf_ff;

   a_ovf_inf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_result_word == fmas_pkg::INF_WORD)
      else $error("overflow without infinity word");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_word))
      else $error("result changed during stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output stage");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v1_ff)
      else $error("accepted item dropped");

endmodule
